>>> sv/hpe_pkg.sv
// Package for the Horner polynomial evaluator.
// Holds the request and result types and the command codes.
// No dependencies.
package hpe_pkg;

    localparam int WORD_W = 32;
    localparam int IDX_IN_W = 4;
    localparam int TERM_CNT_W = 5;

    // Request commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [IDX_IN_W-1:0]      coef_index;
        logic signed [WORD_W-1:0] coef_value;
        logic signed [WORD_W-1:0] x_value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] poly_value;
        logic                     saturated;
    } t_res;

endpackage

>>> sv/hpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/horner_polynomial_evaluator.sv
// Channel   | Direction | Handshake                  | Payload
// request   | in        | start high, busy low       | i_req (hpe_pkg::t_req)
// result    | out       | o_res_valid, one cycle     | o_res (hpe_pkg::t_res)
// config    | in        | i_cfg_we                   | i_cfg_wdata (term count)
//
// A write request stores one coefficient in the same cycle and never raises busy.
// An evaluate request keeps busy high through one coefficient load state, then
// a multiply state and an add state per remaining term on the one shared
// multiplier; the result strobe is registered and rises as busy falls.
// Reset is synchronous, active low; it clears the coefficient valid bits at once.
// The result is shown for one cycle and cannot be stalled.
//
// Top level of the Horner polynomial evaluator.
// Depends on hpe_pkg and hpe_ram.
module horner_polynomial_evaluator #(
    parameter int MAX_TERMS = 16,
    parameter int FRAC_BITS = 30
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  hpe_pkg::t_req                    i_req,
    output logic                             o_res_valid,
    output hpe_pkg::t_res                    o_res,
    input  logic                             i_cfg_we,
    input  logic [hpe_pkg::TERM_CNT_W-1:0]   i_cfg_wdata
);

    import hpe_pkg::*;

    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int SUM_W = 2 * WORD_W + 1;
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'sd1 <<< (WORD_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(64'sd1 <<< (WORD_W - 1));

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_ADD  = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [TERM_CNT_W-1:0]      r_term_count;
    logic [MAX_TERMS-1:0]       r_valid;
    logic                       r_rd_valid;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic signed [WORD_W-1:0]   r_x;
    logic signed [WORD_W-1:0]   r_acc, n_acc;
    logic signed [2*WORD_W-1:0] r_prod;
    logic                       r_flag, n_flag;
    logic                       r_res_valid, n_res_valid;
    t_res                       r_res, n_res;

    logic                       w_accept;
    logic                       w_wr;
    logic [31:0]                w_idx32;
    logic [IDX_W-1:0]           w_waddr;
    logic [31:0]                w_tc32;
    logic [31:0]                w_n;
    logic [31:0]                w_nm1;
    logic [IDX_W-1:0]           w_start;
    logic [IDX_W-1:0]           w_raddr;
    logic [WORD_W-1:0]          w_rdata;
    logic signed [WORD_W-1:0]   w_coef;
    logic signed [2*WORD_W-1:0] w_shift;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [WORD_W-1:0]   w_clip;
    logic                       w_clipped;

    assign busy = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    // Coefficient write decode; drop writes beyond the table
    assign w_idx32 = 32'(i_req.coef_index);
    assign w_waddr = w_idx32[IDX_W-1:0];
    assign w_wr = w_accept && (i_req.cmd == CMD_WRITE) && (w_idx32 < 32'(MAX_TERMS));

    // Clamp the term count to 1..MAX_TERMS and find the top index
    always_comb begin
        w_tc32 = 32'(r_term_count);
        priority if (w_tc32 == 32'd0) begin
            w_n = 32'd1;
        end else if (w_tc32 > 32'(MAX_TERMS)) begin
            w_n = 32'(MAX_TERMS);
        end else begin
            w_n = w_tc32;
        end
        w_nm1 = w_n - 32'd1;
        w_start = w_nm1[IDX_W-1:0];
    end

    // Read the top coefficient while idle, else the current step index
    assign w_raddr = busy ? r_idx : w_start;

    hpe_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_TERMS)
    ) u_coef_ram (
        .i_clk  (i_clk),
        .i_we   (w_wr),
        .i_waddr(w_waddr),
        .i_wdata(i_req.coef_value),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Unwritten entries read as zero
    assign w_coef = r_rd_valid ? $signed(w_rdata) : '0;

    // Truncate the product, add the coefficient, saturate
    always_comb begin
        w_shift = r_prod >>> FRAC_BITS;
        w_sum = SUM_W'(w_shift) + SUM_W'(w_coef);
        w_clipped = 1'b1;
        priority if (w_sum > SUM_MAX) begin
            w_clip = SUM_MAX[WORD_W-1:0];
        end else if (w_sum < SUM_MIN) begin
            w_clip = SUM_MIN[WORD_W-1:0];
        end else begin
            w_clip = w_sum[WORD_W-1:0];
            w_clipped = 1'b0;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_acc = r_acc;
        n_flag = r_flag;
        n_res_valid = 1'b0;
        n_res = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_req.cmd == CMD_EVAL)) begin
                    n_idx = w_start;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_acc = w_coef;
                n_flag = 1'b0;
                if (r_idx == '0) begin
                    n_res_valid = 1'b1;
                    n_res.poly_value = w_coef;
                    n_res.saturated = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_acc = w_clip;
                n_flag = r_flag | w_clipped;
                if (r_idx == '0) begin
                    n_res_valid = 1'b1;
                    n_res.poly_value = w_clip;
                    n_res.saturated = r_flag | w_clipped;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                    n_state = ST_MUL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_term_count <= TERM_CNT_W'(1);
            r_valid <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_term_count <= i_cfg_wdata;
            end
            if (w_wr) begin
                r_valid[w_waddr] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[w_raddr];
        r_idx <= n_idx;
        r_acc <= n_acc;
        r_flag <= n_flag;
        r_res <= n_res;
        if (w_accept) begin
            r_x <= i_req.x_value;
        end
        r_prod <= (2*WORD_W)'(r_acc) * (2*WORD_W)'(r_x);
    end

    assign o_res_valid = r_res_valid;
    assign o_res = r_res;

    // A result only ends an evaluation that held busy
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result strobe without a preceding evaluation");

    // An accepted write request produces no result
    a_write_no_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.cmd == CMD_WRITE)) |=> !o_res_valid)
        else $error("write request produced a result");

    // An accepted evaluate request raises busy
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.cmd == CMD_EVAL)) |=> busy)
        else $error("evaluate request did not start the sequencer");

endmodule
